// File: src/lbf_pkg.sv
package lbf_pkg;

  localparam int TableEntries = 64;
  localparam int MaxPorts     = 8;
  localparam int MacW         = 48;
  localparam int PortW        = 3;
  localparam int TimeW        = 32;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int PcntW        = 4;

  localparam logic [1:0] KIND_RX   = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] CLS_HOST  = 2'd0;
  localparam logic [1:0] CLS_GROUP = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  localparam logic [1:0] CFG_LEARN  = 2'd0;
  localparam logic [1:0] CFG_EXPIRY = 2'd1;
  localparam logic [1:0] CFG_MAC    = 2'd2;
  localparam logic [1:0] CFG_PORTS  = 2'd3;

  // Operation travelling down the cell chain.
  typedef struct packed {
    logic              vld;
    logic              do_learn;
    logic              do_look;
    logic [MacW-1:0]   src;
    logic [MacW-1:0]   dst;
    logic [PortW-1:0]  port;
    logic [TimeW-1:0]  now;
    logic [TimeW-1:0]  exp;
    // learn progress
    logic              src_hit;
    logic              free_seen;
    logic [IdxW-1:0]   free_idx;
    // lookup progress
    logic              dst_done;
    logic              dst_live;
    logic [PortW-1:0]  dst_port;
  } lbf_op_t;

  // Second pass: commit a learn into the chosen slot.
  // keep low writes the slot as invalid (entry dead on arrival).
  typedef struct packed {
    logic              vld;
    logic              keep;
    logic [IdxW-1:0]   idx;
    logic [MacW-1:0]   mac;
    logic [PortW-1:0]  port;
    logic [TimeW-1:0]  exp;
  } lbf_wr_t;

  function automatic logic is_live(input logic [TimeW-1:0] exp,
                                   input logic [TimeW-1:0] now);
    logic [TimeW-1:0] d;
    d = exp - now;
    return (d != '0) && !d[TimeW-1];
  endfunction

endpackage

// File: src/lbf_cell.sv
module lbf_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [lbf_pkg::IdxW-1:0]              my_idx,
  input  lbf_pkg::lbf_op_t                      op_i,
  input  lbf_pkg::lbf_wr_t                      wr_i,
  output lbf_pkg::lbf_op_t                      op_o
);
  logic                         vld_r;
  logic [lbf_pkg::MacW-1:0]     mac_r;
  logic [lbf_pkg::PortW-1:0]    port_r;
  logic [lbf_pkg::TimeW-1:0]    exp_r;
  lbf_pkg::lbf_op_t             op_r, op_nxt;
  logic                         live, smatch, dmatch;

  assign live   = lbf_pkg::is_live(exp_r, op_i.now);
  assign smatch = vld_r && (mac_r == op_i.src);
  assign dmatch = vld_r && (mac_r == op_i.dst);

  always_comb begin
    op_nxt = op_i;
    if (op_i.vld && op_i.do_learn && !op_i.src_hit) begin
      if (smatch) begin
        op_nxt.src_hit  = 1'b1;
        op_nxt.free_idx = my_idx;
      end else if (!op_i.free_seen && (!vld_r || !live)) begin
        op_nxt.free_seen = 1'b1;
        op_nxt.free_idx  = my_idx;
      end
    end
    if (op_i.vld && op_i.do_look && !op_i.dst_done && dmatch) begin
      op_nxt.dst_done = 1'b1;
      op_nxt.dst_live = live;
      op_nxt.dst_port = port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r  <= '0;
      vld_r <= 1'b0;
    end else begin
      op_r <= op_nxt;
      if (wr_i.vld && wr_i.idx == my_idx) begin
        vld_r  <= wr_i.keep;
        mac_r  <= wr_i.mac;
        port_r <= wr_i.port;
        exp_r  <= wr_i.exp;
      end else if (op_i.vld && op_i.do_look && !op_i.dst_done && dmatch && !live) begin
        vld_r <= 1'b0;
      end
    end
  end

  assign op_o = op_r;
endmodule

// File: src/learning_bridge_forwarder.sv
// MAC learning bridge. Pulse start with an event while busy is low; a frame or
// local send then holds busy high while the event walks a chain of 64 cells,
// each holding one table entry, one cell per cycle. Learn search and
// destination lookup ride the same beat; the learn is written and the result
// shows on out_valid in the cycle busy falls, and the next event can be taken
// at the end of that cycle. The receiver cannot stall the result. Ticks,
// frames for the own address and dropped frames do not raise busy. Config
// writes only while idle.
module learning_bridge_forwarder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [47:0] in_src_mac,
  input  logic [47:0] in_dst_mac,
  input  logic [2:0]  in_in_port,
  input  logic [1:0]  in_frame_class,
  output logic        out_valid,
  output logic        out_deliver_local,
  output logic [7:0]  out_port_mask,
  output logic        out_flooded
);
  localparam int N = lbf_pkg::TableEntries;

  logic        learn_en_r;
  logic [30:0] expiry_r;
  logic [47:0] own_mac_r;
  logic [3:0]  pcnt_r;
  logic [lbf_pkg::TimeW-1:0] now_r;

  lbf_pkg::lbf_op_t chain [0:N];
  lbf_pkg::lbf_wr_t wr;
  lbf_pkg::lbf_op_t op_in;

  logic        busy_r;
  logic        tail_tx_r;
  logic        tail_grp_r;

  // ports in use, clamped to 1..MaxPorts
  logic [3:0] npt;
  logic [lbf_pkg::MaxPorts-1:0] allp;
  always_comb begin
    npt = pcnt_r;
    if (npt == 4'd0) npt = 4'd1;
    if (npt > 4'(lbf_pkg::MaxPorts)) npt = 4'(lbf_pkg::MaxPorts);
    allp = '0;
    for (int k = 0; k < lbf_pkg::MaxPorts; k++) allp[k] = (4'(k) < npt);
  end

  logic acc;
  logic pdrop;
  assign acc   = start && !busy;
  assign pdrop = ({1'b0, in_in_port} >= npt);

  always_comb begin
    op_in          = '0;
    op_in.src      = in_src_mac;
    op_in.dst      = in_dst_mac;
    op_in.port     = in_in_port;
    op_in.now      = now_r;
    op_in.exp      = now_r + {1'b0, expiry_r};
    op_in.vld      = 1'b0;
    if (acc && in_kind == lbf_pkg::KIND_TX) begin
      op_in.vld     = 1'b1;
      op_in.do_look = learn_en_r && !in_dst_mac[40];
    end else if (acc && in_kind == lbf_pkg::KIND_RX && !pdrop) begin
      if (in_frame_class == lbf_pkg::CLS_GROUP) begin
        op_in.vld      = 1'b1;
        op_in.do_learn = learn_en_r;
      end else if (in_frame_class == lbf_pkg::CLS_OTHER && in_dst_mac != own_mac_r) begin
        op_in.vld      = 1'b1;
        op_in.do_learn = learn_en_r;
        op_in.do_look  = learn_en_r;
      end
    end
  end

  // Lookup sees the table before this beat's learn; a learn of the same
  // address as dst gives the same port, except aliasing of src==dst, handled
  // below by preferring the learned values.
  assign chain[0] = op_in;
  for (genvar g = 0; g < N; g++) begin : g_cell
    lbf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (lbf_pkg::IdxW'(g)),
      .op_i    (chain[g]),
      .wr_i    (wr),
      .op_o    (chain[g+1])
    );
  end

  lbf_pkg::lbf_op_t eo;
  assign eo = chain[N];
  always_comb begin
    wr      = '0;
    wr.vld  = eo.vld && eo.do_learn && (eo.src_hit || eo.free_seen);
    // src==dst learned with zero lifetime: the lookup right after kills it
    wr.keep = !(eo.do_look && eo.src == eo.dst && !lbf_pkg::is_live(eo.exp, eo.now));
    wr.idx  = eo.free_idx;
    wr.mac  = eo.src;
    wr.port = eo.port;
    wr.exp  = eo.exp;
  end

  // Result decision for the beat leaving the chain.
  logic       hit;
  logic [2:0] hport;
  always_comb begin
    hit   = eo.do_look && eo.dst_done && eo.dst_live;
    hport = eo.dst_port;
    // learn of src equal to dst updates that entry first
    if (eo.do_look && eo.do_learn && eo.src == eo.dst && wr.vld) begin
      hit   = lbf_pkg::is_live(eo.exp, eo.now);
      hport = eo.port;
    end
    if (hit && ({1'b0, hport} >= npt)) hit = 1'b0;
  end

  logic [7:0] flood_rx;
  assign flood_rx = 8'(allp & ~(lbf_pkg::MaxPorts'(1) << eo.port));

  // own-address delivery answers at once; chain results when the beat exits
  logic res_local, res_chain;
  assign res_local = acc && in_kind == lbf_pkg::KIND_RX && !pdrop &&
                     (in_frame_class == lbf_pkg::CLS_HOST ||
                      in_frame_class == lbf_pkg::CLS_OTHER) &&
                     in_dst_mac == own_mac_r;
  assign res_chain = busy_r && eo.vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_en_r <= 1'b1;
      expiry_r   <= 31'd300;
      own_mac_r  <= '0;
      pcnt_r     <= 4'd8;
      now_r      <= '0;
      busy_r     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= res_local || res_chain;
      if (cfg_we) begin
        unique case (cfg_index)
          lbf_pkg::CFG_LEARN:  learn_en_r <= cfg_data[0];
          lbf_pkg::CFG_EXPIRY: expiry_r   <= cfg_data[30:0];
          lbf_pkg::CFG_MAC:    own_mac_r  <= cfg_data;
          lbf_pkg::CFG_PORTS:  pcnt_r     <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (acc) begin
        if (in_kind == lbf_pkg::KIND_TICK) now_r <= now_r + 1'b1;
        if (res_local) begin
          out_deliver_local <= 1'b1;
          out_port_mask     <= '0;
          out_flooded       <= 1'b0;
        end
        if (op_in.vld) begin
          busy_r     <= 1'b1;
          tail_tx_r  <= (in_kind == lbf_pkg::KIND_TX);
          tail_grp_r <= (in_frame_class == lbf_pkg::CLS_GROUP);
        end
      end else if (res_chain) begin
        if (tail_tx_r) begin
          out_deliver_local <= 1'b0;
          out_port_mask     <= hit ? 8'(8'd1 << hport) : 8'(allp);
          out_flooded       <= !hit;
        end else if (tail_grp_r) begin
          out_deliver_local <= 1'b1;
          out_port_mask     <= flood_rx;
          out_flooded       <= 1'b1;
        end else begin
          out_deliver_local <= 1'b0;
          if (hit && hport != eo.port) begin
            out_port_mask <= 8'(8'd1 << hport);
            out_flooded   <= 1'b0;
          end else begin
            out_port_mask <= flood_rx;
            out_flooded   <= 1'b1;
          end
        end
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
endmodule

// File: test/tb_learning_bridge_forwarder.sv
`timescale 1ns / 1ps

module tb_learning_bridge_forwarder;

  localparam int WatchdogLimit = 5000;

  // unused codes, sent to check they are ignored
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] CLS_NONE  = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [47:0] in_src_mac;
  logic [47:0] in_dst_mac;
  logic [2:0]  in_in_port;
  logic [1:0]  in_frame_class;
  logic        out_valid;
  logic        out_deliver_local;
  logic [7:0]  out_port_mask;
  logic        out_flooded;

  learning_bridge_forwarder dut (.*);

  // One forwarding decision as seen on the result ports.
  typedef struct packed {
    logic       deliver;
    logic [7:0] mask;
    logic       flood;
  } decision_t;

  // Shadow of the bridge's registers and MAC table.
  logic                      m_learn_en;
  logic [30:0]               m_expiry;
  logic [lbf_pkg::MacW-1:0]  m_own_mac;
  logic [3:0]                m_port_count;
  logic                      tbl_valid [lbf_pkg::TableEntries];
  logic [lbf_pkg::MacW-1:0]  tbl_mac   [lbf_pkg::TableEntries];
  logic [lbf_pkg::PortW-1:0] tbl_port  [lbf_pkg::TableEntries];
  logic [lbf_pkg::TimeW-1:0] tbl_exp   [lbf_pkg::TableEntries];
  logic [lbf_pkg::TimeW-1:0] m_now;

  decision_t pending_decisions[$];
  int        fail_count;
  int        idle_cycles;
  int        send_idle_pct;
  logic [lbf_pkg::MacW-1:0] host_pool [16];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int ports_used();
    int n;
    n = m_port_count;
    if (n == 0) n = 1;
    if (n > lbf_pkg::MaxPorts) n = lbf_pkg::MaxPorts;
    return n;
  endfunction

  function automatic logic [7:0] flood_mask();
    return 8'((9'd1 << ports_used()) - 9'd1);
  endfunction

  function automatic logic entry_live(int i);
    logic [lbf_pkg::TimeW-1:0] d;
    d = tbl_exp[i] - m_now;
    return (d != 0) && !d[lbf_pkg::TimeW-1];
  endfunction

  function automatic void add_decision(logic deliver, logic [7:0] mask, logic flood);
    decision_t d;
    d = '{deliver, mask, flood};
    pending_decisions = {pending_decisions, d};
  endfunction

  task automatic table_learn(logic [lbf_pkg::MacW-1:0] mac, logic [lbf_pkg::PortW-1:0] port);
    int slot;
    slot = -1;
    if (!m_learn_en) return;
    for (int i = 0; i < lbf_pkg::TableEntries; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) begin
        slot = i;
        break;
      end
    if (slot < 0)
      for (int i = 0; i < lbf_pkg::TableEntries; i++)
        if (!tbl_valid[i] || !entry_live(i)) begin
          slot = i;
          break;
        end
    if (slot < 0) return;
    tbl_valid[slot] = 1'b1;
    tbl_mac[slot]   = mac;
    tbl_port[slot]  = port;
    tbl_exp[slot]   = m_now + {1'b0, m_expiry};
  endtask

  // Returns learned port or -1; stale matches get invalidated.
  function automatic int table_lookup(logic [lbf_pkg::MacW-1:0] mac);
    if (!m_learn_en) return -1;
    for (int i = 0; i < lbf_pkg::TableEntries; i++)
      if (tbl_valid[i] && tbl_mac[i] == mac) begin
        if (!entry_live(i)) begin
          tbl_valid[i] = 1'b0;
          return -1;
        end
        if (tbl_port[i] >= ports_used()) return -1;
        return tbl_port[i];
      end
    return -1;
  endfunction

  // Forwarding decision for one event; queues it if the event yields one.
  task automatic forward_event(logic [1:0] kind, logic [lbf_pkg::MacW-1:0] src,
                               logic [lbf_pkg::MacW-1:0] dst,
                               logic [2:0] port, logic [1:0] cls);
    int hit;
    logic [7:0] others;
    others = flood_mask() & ~(8'd1 << port);
    if (kind == lbf_pkg::KIND_TICK) begin
      m_now++;
      return;
    end
    if (kind == lbf_pkg::KIND_TX) begin
      if (!dst[40]) begin
        hit = table_lookup(dst);
        if (hit >= 0) begin
          add_decision(1'b0, 8'(8'd1 << hit), 1'b0);
          return;
        end
      end
      add_decision(1'b0, flood_mask(), 1'b1);
      return;
    end
    if (kind != lbf_pkg::KIND_RX || port >= ports_used()) return;
    case (cls)
      lbf_pkg::CLS_HOST: begin
        if (dst == m_own_mac) add_decision(1'b1, 8'd0, 1'b0);
      end
      lbf_pkg::CLS_GROUP: begin
        table_learn(src, port);
        add_decision(1'b1, others, 1'b1);
      end
      lbf_pkg::CLS_OTHER: begin
        if (dst == m_own_mac) begin
          add_decision(1'b1, 8'd0, 1'b0);
        end else begin
          table_learn(src, port);
          hit = table_lookup(dst);
          if (hit >= 0 && hit != port)
            add_decision(1'b0, 8'(8'd1 << hit), 1'b0);
          else
            add_decision(1'b0, others, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  // Result checker: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    decision_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_deliver_local, out_port_mask, out_flooded};
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_decisions.pop_front();
        if (got.deliver !== want.deliver) begin
          $display("%0t: deliver_local expected %0b actual %0b", $time, want.deliver,
                   got.deliver);
          fail_count++;
        end
        if (got.mask !== want.mask) begin
          $display("%0t: port_mask expected %h actual %h", $time, want.mask, got.mask);
          fail_count++;
        end
        if (got.flood !== want.flood) begin
          $display("%0t: flooded expected %0b actual %0b", $time, want.flood, got.flood);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no beat accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      lbf_pkg::CFG_LEARN:  m_learn_en   = val[0];
      lbf_pkg::CFG_EXPIRY: m_expiry     = val[30:0];
      lbf_pkg::CFG_MAC:    m_own_mac    = val;
      lbf_pkg::CFG_PORTS:  m_port_count = val[3:0];
      default: ;
    endcase
  endtask

  // Sends one event beat; random idle before it per current sender load.
  task automatic send_event(logic [1:0] kind, logic [lbf_pkg::MacW-1:0] src,
                            logic [lbf_pkg::MacW-1:0] dst,
                            logic [2:0] port, logic [1:0] cls);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    start          <= 1'b1;
    in_kind        <= kind;
    in_src_mac     <= src;
    in_dst_mac     <= dst;
    in_in_port     <= port;
    in_frame_class <= cls;
    @(posedge clk);
    while (busy) @(posedge clk);
    forward_event(kind, src, dst, port, cls);
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all results, then the block's full walk before touching config.
  task automatic drain();
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_ticks(int n);
    for (int i = 0; i < n; i++) send_event(lbf_pkg::KIND_TICK, '0, '0, '0, '0);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    reg_write(lbf_pkg::CFG_MAC, 48'h0200_0000_00AA);
    // group frame learns its source, floods to others
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_0011, 48'hFFFF_FFFF_FFFF, 3'd2,
               lbf_pkg::CLS_GROUP);
    // unicast to learned host on another port
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_0022, 48'h0000_0000_0011, 3'd5,
               lbf_pkg::CLS_OTHER);
    // learned on the ingress port: floods
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_0033, 48'h0000_0000_0011, 3'd2,
               lbf_pkg::CLS_OTHER);
    send_event(lbf_pkg::KIND_RX, 48'hFFFF_FFFF_FFFF, 48'h0200_0000_00AA, 3'd7,
               lbf_pkg::CLS_HOST);
    send_event(lbf_pkg::KIND_RX, '0, 48'h0000_0000_0001, 3'd0, lbf_pkg::CLS_HOST);
    send_event(lbf_pkg::KIND_RX, '0, 48'h0200_0000_00AA, 3'd1, lbf_pkg::CLS_OTHER);
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_0044, 48'h0000_0000_0011, 3'd1, CLS_NONE);
    send_event(KIND_NONE, 48'h0000_0000_0055, 48'h0000_0000_0011, 3'd1,
               lbf_pkg::CLS_OTHER);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0000_0000_0022, 3'd0, lbf_pkg::CLS_HOST);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0100_0000_0022, 3'd0, lbf_pkg::CLS_HOST);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0000_0000_0099, 3'd0, lbf_pkg::CLS_HOST);
    drain();
    // fewer ports: ingress out of range drops, learned port out of range misses
    reg_write(lbf_pkg::CFG_PORTS, 48'd3);
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_0066, 48'h0000_0000_0022, 3'd6,
               lbf_pkg::CLS_OTHER);
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_0077, 48'h0000_0000_0022, 3'd1,
               lbf_pkg::CLS_OTHER);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0000_0000_0011, 3'd0, lbf_pkg::CLS_HOST);
    drain();
    reg_write(lbf_pkg::CFG_PORTS, 48'd0);
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_0088, 48'hFFFF_FFFF_FFFF, 3'd0,
               lbf_pkg::CLS_GROUP);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0000_0000_0011, 3'd0, lbf_pkg::CLS_HOST);
    drain();
    reg_write(lbf_pkg::CFG_PORTS, 48'd15);
    // short expiry: entry ages out and a lookup invalidates it
    reg_write(lbf_pkg::CFG_EXPIRY, 48'd2);
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_00C1, 48'hFFFF_FFFF_FFFF, 3'd4,
               lbf_pkg::CLS_GROUP);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0000_0000_00C1, 3'd0, lbf_pkg::CLS_HOST);
    send_ticks(2);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0000_0000_00C1, 3'd0, lbf_pkg::CLS_HOST);
    drain();
    reg_write(lbf_pkg::CFG_EXPIRY, 48'd0);
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_00C2, 48'h0000_0000_00C2, 3'd3,
               lbf_pkg::CLS_OTHER);
    drain();
    reg_write(lbf_pkg::CFG_EXPIRY, 48'h7FFF_FFFF);
    reg_write(lbf_pkg::CFG_LEARN, 48'd0);
    send_event(lbf_pkg::KIND_RX, 48'h0000_0000_00D1, 48'h0000_0000_0011, 3'd1,
               lbf_pkg::CLS_OTHER);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0000_0000_00D1, 3'd0, lbf_pkg::CLS_HOST);
    drain();
    reg_write(lbf_pkg::CFG_LEARN, 48'd1);
  endtask

  // Fill the table with live entries so a learn must be skipped, then age them.
  task automatic test_table_full();
    send_idle_pct = 0;
    reg_write(lbf_pkg::CFG_EXPIRY, 48'd5);
    for (int i = 0; i < lbf_pkg::TableEntries + 2; i++)
      send_event(lbf_pkg::KIND_RX, 48'h0A00_0000_0000 + 48'(i), 48'hFFFF_FFFF_FFFF, 3'(i),
                 lbf_pkg::CLS_GROUP);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0A00_0000_0041, 3'd0, lbf_pkg::CLS_HOST);
    send_ticks(5);
    send_event(lbf_pkg::KIND_RX, 48'h0A00_0000_0100, 48'h0A00_0000_0003, 3'd6,
               lbf_pkg::CLS_OTHER);
    send_event(lbf_pkg::KIND_TX, '0, 48'h0A00_0000_0100, 3'd0, lbf_pkg::CLS_HOST);
    drain();
  endtask

  function automatic logic [lbf_pkg::MacW-1:0] pick_mac();
    if ($urandom_range(9) < 8) return host_pool[$urandom_range(15)];
    if ($urandom_range(3) == 0) return m_own_mac;
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic random_phase(int n, int idle_pct);
    int r;
    logic [1:0] kind;
    send_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      kind = r < 60 ? lbf_pkg::KIND_RX : r < 80 ? lbf_pkg::KIND_TX :
             r < 97 ? lbf_pkg::KIND_TICK : KIND_NONE;
      send_event(kind, pick_mac(), pick_mac(), 3'($urandom_range(7)),
                 $urandom_range(9) == 0 ? CLS_NONE : 2'($urandom_range(2)));
    end
    drain();
  endtask

  task automatic test_random();
    for (int i = 0; i < 16; i++) host_pool[i] = 48'({$urandom(), $urandom()});
    host_pool[0] = '0;
    host_pool[1] = '1;
    reg_write(lbf_pkg::CFG_EXPIRY, 48'd40);
    reg_write(lbf_pkg::CFG_MAC, host_pool[2]);
    random_phase(400, 0);
    reg_write(lbf_pkg::CFG_PORTS, 48'($urandom_range(1, 7)));
    reg_write(lbf_pkg::CFG_EXPIRY, 48'd6);
    random_phase(350, 74);
    reg_write(lbf_pkg::CFG_PORTS, 48'd8);
    reg_write(lbf_pkg::CFG_EXPIRY, 48'd300);
    reg_write(lbf_pkg::CFG_MAC, 48'hFFFF_FFFF_FFFF);
    random_phase(350, 37);
    reg_write(lbf_pkg::CFG_LEARN, 48'd0);
    random_phase(100, 0);
    reg_write(lbf_pkg::CFG_LEARN, 48'd1);
    reg_write(lbf_pkg::CFG_EXPIRY, 48'd15);
    random_phase(300, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    in_kind = '0;
    in_src_mac = '0;
    in_dst_mac = '0;
    in_in_port = '0;
    in_frame_class = '0;
    fail_count = 0;
    send_idle_pct = 0;
    m_learn_en = 1'b1;
    m_expiry = 31'd300;
    m_own_mac = '0;
    m_port_count = 4'd8;
    m_now = '0;
    for (int i = 0; i < lbf_pkg::TableEntries; i++) tbl_valid[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random();
    drain();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
src/lbf_pkg.sv
src/lbf_cell.sv
src/learning_bridge_forwarder.sv
test/tb_learning_bridge_forwarder.sv
